/* rtl/core/fct_pkg.sv */
package fct_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEFS          = 4;
  localparam int CORNER_W       = 3;
  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_BOX    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         plane_index;
    logic [1:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } in_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] test_kind;
  } out_t;

  typedef struct packed {
    logic                start;
    logic                issue;
    logic [CORNER_W-1:0] corner;
    logic                load_out;
  } ctl_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

/* rtl/core/fct_ctrl.sv */
module fct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_cmd,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fct_pkg::sts_t sts,
  output fct_pkg::ctl_t ctl
);

  fct_pkg::state_t                  state_r, state_nxt;
  logic [fct_pkg::CORNER_W-1:0]     cnt_r, cnt_nxt;
  logic                             box_r, box_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fct_pkg::ST_IDLE;
      cnt_r       <= '0;
      box_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      box_r       <= box_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    box_nxt      = box_r;
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.corner   = cnt_r;
    fire         = 1'b0;
    case (state_r)
      fct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        fire     = in_valid;
        if (fire && (in_cmd != fct_pkg::CMD_WRITE)) begin
          ctl.start = 1'b1;
          cnt_nxt   = '0;
          box_nxt   = (in_cmd == fct_pkg::CMD_BOX);
          state_nxt = fct_pkg::ST_ISSUE;
        end
      end
      fct_pkg::ST_ISSUE: begin
        ctl.issue = 1'b1;
        if (!box_r || (cnt_r == fct_pkg::LAST_CORNER)) begin
          state_nxt = fct_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      fct_pkg::ST_DRAIN: begin
        if (!sts.busy && (!out_valid_r || out_ready)) begin
          ctl.load_out = 1'b1;
          state_nxt    = fct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fct_pkg::ST_IDLE;
      end
    endcase
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/fct_datapath.sv */
module fct_datapath #(
  parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF,
  parameter int FRAC_BITS  = fct_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  fct_pkg::in_t  in_data,
  input  fct_pkg::ctl_t ctl,
  output fct_pkg::sts_t sts,
  output fct_pkg::out_t out_data
);

  localparam int ACC_W = 67;
  localparam int DB_W  = 34;

  logic signed [31:0] coef_r [NUM_PLANES][fct_pkg::COEFS];

  logic [1:0]         cmd_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic [30:0]        rad_r, hx_r, hy_r, hz_r;
  logic [30:0]        hx_e, hy_e, hz_e, rad_e;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic               vc_r, vp_r, vs_r;
  logic               pass_r;
  logic [NUM_PLANES-1:0] lane_ok;
  fct_pkg::out_t      out_r;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic [30:0] h,
                                                 input logic up);
    logic signed [32:0] s;
    if (up) begin
      s = $signed({a[31], a}) + $signed({2'b00, h});
    end else begin
      s = $signed({a[31], a}) - $signed({2'b00, h});
    end
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < fct_pkg::COEFS; c++) begin
          coef_r[p][c] <= '0;
        end
      end
    end else if (in_fire && (in_data.command == fct_pkg::CMD_WRITE)) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < fct_pkg::COEFS; c++) begin
          if ((5'(in_data.plane_index) == 5'(p)) && (in_data.coeff_index == 2'(c))) begin
            coef_r[p][c] <= in_data.coeff_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_data.command;
      x_r   <= in_data.pos_x;
      y_r   <= in_data.pos_y;
      z_r   <= in_data.pos_z;
      rad_r <= in_data.radius;
      hx_r  <= in_data.half_x;
      hy_r  <= in_data.half_y;
      hz_r  <= in_data.half_z;
    end
  end

  assign hx_e  = (cmd_r == fct_pkg::CMD_BOX) ? hx_r : '0;
  assign hy_e  = (cmd_r == fct_pkg::CMD_BOX) ? hy_r : '0;
  assign hz_e  = (cmd_r == fct_pkg::CMD_BOX) ? hz_r : '0;
  assign rad_e = (cmd_r == fct_pkg::CMD_SPHERE) ? rad_r : '0;

  // corner stage
  always_ff @(posedge clk) begin
    cx_r <= sat_add(x_r, hx_e, ctl.corner[0]);
    cy_r <= sat_add(y_r, hy_e, ctl.corner[1]);
    cz_r <= sat_add(z_r, hz_e, ctl.corner[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vp_r <= 1'b0;
      vs_r <= 1'b0;
    end else begin
      vc_r <= ctl.issue;
      vp_r <= vc_r;
      vs_r <= vp_r;
    end
  end

  // one lane per plane: products, partial sums, sign
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    logic signed [63:0]      px_r, py_r, pz_r;
    logic signed [DB_W-1:0]  db_r;
    logic signed [ACC_W-1:0] s1_r, s2_r, tot;

    always_ff @(posedge clk) begin
      px_r <= coef_r[p][0] * cx_r;
      py_r <= coef_r[p][1] * cy_r;
      pz_r <= coef_r[p][2] * cz_r;
      db_r <= $signed({{2{coef_r[p][3][31]}}, coef_r[p][3]}) + $signed({3'b000, rad_e});
      s1_r <= ACC_W'(px_r) + ACC_W'(py_r);
      s2_r <= ACC_W'(pz_r) + (ACC_W'(db_r) <<< FRAC_BITS);
    end

    assign tot        = s1_r + s2_r;
    assign lane_ok[p] = !tot[ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      pass_r <= 1'b1;
    end else if (vs_r) begin
      pass_r <= pass_r & (&lane_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_r.inside_res <= pass_r;
      out_r.test_kind  <= cmd_r;
    end
  end

  assign sts.busy = vc_r | vp_r | vs_r;
  assign out_data = out_r;

endmodule

/* rtl/core/frustum_cull_tester.sv */
// Writes: no result; the next item may follow in the next cycle.
// Point and sphere tests: the next item is accepted only after the result is
// loaded into the output register. Box tests: all 8 corners go through the
// plane lanes; the next item likewise waits for the result.
// Sync active-low reset clears the control state and zeros the plane table.
module frustum_cull_tester #(
  parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF,
  parameter int FRAC_BITS  = fct_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fct_pkg::out_t out_data
);

  fct_pkg::ctl_t ctl;
  fct_pkg::sts_t sts;
  logic          in_fire;

  assign in_fire = in_valid & in_ready;

  fct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fct_datapath #(
    .NUM_PLANES (NUM_PLANES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* rtl/core/fct_checker.sv */
module fct_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input fct_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input fct_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed before transfer");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.test_kind != fct_pkg::CMD_WRITE))
    else $error("result carries write kind");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command != fct_pkg::CMD_WRITE) |=> !in_ready)
    else $error("ready high right after test transfer");

endmodule

bind frustum_cull_tester fct_checker u_fct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
